@@ rtl/core/sm4bcm_pkg.sv @@
// ============================================================================
// sm4bcm_pkg
// Shared types, constants and helper functions for the SM4 block cipher core
// (S-box, system parameter FK, CK generation, payload structs, codes).
// ============================================================================
package sm4bcm_pkg;

    // Round count and round index width
    localparam int ROUNDS = 32;
    localparam int RND_W  = $clog2(ROUNDS);

    // Configuration index width
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_HIGH    = 3'd0,
        CFG_KEY_LOW     = 3'd1,
        CFG_IV_HIGH     = 3'd2,
        CFG_IV_LOW      = 3'd3,
        CFG_CHAIN_MODE  = 3'd4,
        CFG_DECRYPT_DIR = 3'd5
    } cfg_index_t;

    // Chaining modes
    typedef enum logic [1:0] {
        MODE_ECB = 2'd0,
        MODE_CBC = 2'd1,
        MODE_OFB = 2'd2,
        MODE_CFB = 2'd3
    } chain_mode_t;

    // System parameter FK, first word in the top bits
    localparam logic [127:0] SM4_FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

    // Byte substitution box
    localparam logic [7:0] SM4_SBOX [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    // Four round words, word 0 is X0 (the oldest)
    typedef logic [3:0][31:0] words_t;

    // Input request payload
    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic        first_block;
    } in_t;

    // Output request payload
    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_t;

    // Round key store write port
    typedef struct packed {
        logic             en;
        logic [RND_W-1:0] addr;
        logic [31:0]      data;
    } ks_wr_t;

    // CK word: byte j is (4*i + j) * 7 mod 256, MSB first
    function automatic logic [31:0] ck_word(input logic [RND_W-1:0] idx);
        logic [31:0] w;
        logic [7:0]  base;
        base = {1'b0, idx, 2'b00};
        for (int j = 0; j < 4; j++)
        begin
            w[8*(3-j) +: 8] = 8'((base + 8'(j)) * 8'd7);
        end
        return w;
    endfunction

    // Big-endian 128-bit block to round words (X0 from the top bits)
    function automatic words_t to_words(input logic [127:0] blk);
        words_t w;
        w[0] = blk[127:96];
        w[1] = blk[95:64];
        w[2] = blk[63:32];
        w[3] = blk[31:0];
        return w;
    endfunction

endpackage

@@ rtl/core/sm4bcm_round.sv @@
// ============================================================================
// sm4bcm_round
// Shared SM4 round unit: S-box layer followed by L (data) or L' (key
// schedule), producing the new word X0 ^ T(X1 ^ X2 ^ X3 ^ rk).
// ============================================================================
module sm4bcm_round
    import sm4bcm_pkg::*;
(
    input  words_t      words,
    input  logic [31:0] rk,
    input  logic        key_sched,
    output logic [31:0] next_word
);

    logic [31:0] t_in;
    logic [31:0] b;
    logic [31:0] l_data;
    logic [31:0] l_key;

    // Non-linear layer
    assign t_in = words[1] ^ words[2] ^ words[3] ^ rk;
    assign b    = {SM4_SBOX[t_in[31:24]], SM4_SBOX[t_in[23:16]],
                   SM4_SBOX[t_in[15:8]],  SM4_SBOX[t_in[7:0]]};

    // Linear layers
    assign l_data = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                      ^ {b[13:0], b[31:14]} ^ {b[7:0],  b[31:8]};
    assign l_key  = b ^ {b[18:0], b[31:19]} ^ {b[8:0],  b[31:9]};

    assign next_word = words[0] ^ (key_sched ? l_key : l_data);

endmodule

@@ rtl/core/sm4bcm_key_store.sv @@
// ============================================================================
// sm4bcm_key_store
// Round key memory: 32 x 32 bit, one write port, one registered read port.
// ============================================================================
module sm4bcm_key_store
    import sm4bcm_pkg::*;
(
    input  logic             clk,
    input  ks_wr_t           wr,
    input  logic [RND_W-1:0] rd_addr,
    output logic [31:0]      rd_data
);

    logic [31:0] mem [ROUNDS];
    logic [31:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/sm4_block_cipher_modes_core.sv @@
// ============================================================================
// sm4_block_cipher_modes_core
// SM4-128 core with ECB, CBC, OFB and CFB chaining in both directions.
// ============================================================================
// Usage:
//   cfg channel: valid/ready writes of key, IV, chain mode and direction by
//   index; always ready. Write only while the core is idle.
//   in channel: one 128-bit block per request; first_block starts a message
//   (round keys rebuilt from the key registers, chaining value set to the IV).
//   out channel: one 128-bit block per input request, held in an output
//   register until taken.
// Timing: one shared round unit does one round per cycle. A block continuing
//   a message runs 32 cipher rounds and then a finishing state that writes
//   the output register; a first_block request first runs 32 key schedule
//   rounds and a load state. in_stall is high from acceptance until the
//   result is placed, so a new block is taken only after the previous one
//   has finished.
// Reset: control, configuration and chaining value clear; the round keys are
//   unknown until the first first_block request.
// Stall: a stalled result holds in the output register; the core accepts the
//   next block meanwhile and waits before writing its own result.
// ============================================================================
module sm4_block_cipher_modes_core
    import sm4bcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    // Input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_t                  in_data,
    // Output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_t                 out_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEYGEN,
        ST_PREP,
        ST_CRYPT,
        ST_FINISH
    } state_t;

    // Configuration registers
    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    logic [63:0]  iv_high_reg;
    logic [63:0]  iv_low_reg;
    chain_mode_t  chain_mode_reg;
    logic         decrypt_dir_reg;

    // Sequencer and datapath registers
    state_t             state_reg,     state_next;
    logic [RND_W-1:0]   cnt_reg,       cnt_next;
    words_t             words_reg,     words_next;
    logic [127:0]       blk_reg,       blk_next;
    logic [127:0]       chain_reg,     chain_next;
    chain_mode_t        mode_reg,      mode_next;
    logic               dec_reg,       dec_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_data_reg,  out_data_next;

    logic               in_accept;
    logic               cfg_rev;
    logic               rev;
    logic [RND_W-1:0]   rd_round;
    logic [RND_W-1:0]   rd_addr;
    logic [31:0]        rk_mem;
    logic [31:0]        rk;
    logic               key_sched;
    logic [31:0]        round_out;
    ks_wr_t             ks_wr;
    logic [127:0]       ks;
    logic [127:0]       blk_in;

    // Cipher input for the chosen mode
    function automatic words_t cipher_src(input chain_mode_t mode, input logic dec,
                                          input logic [127:0] blk,
                                          input logic [127:0] chain);
        logic [127:0] src;
        case (mode)
            MODE_ECB: src = blk;
            MODE_CBC: src = dec ? blk : (chain ^ blk);
            MODE_OFB: src = chain;
            MODE_CFB: src = chain;
            default:  src = blk;
        endcase
        return to_words(src);
    endfunction

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg    <= '0;
            key_low_reg     <= '0;
            iv_high_reg     <= '0;
            iv_low_reg      <= '0;
            chain_mode_reg  <= MODE_ECB;
            decrypt_dir_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_HIGH:    key_high_reg    <= cfg_data;
                CFG_KEY_LOW:     key_low_reg     <= cfg_data;
                CFG_IV_HIGH:     iv_high_reg     <= cfg_data;
                CFG_IV_LOW:      iv_low_reg      <= cfg_data;
                CFG_CHAIN_MODE:  chain_mode_reg  <= chain_mode_t'(cfg_data[1:0]);
                CFG_DECRYPT_DIR: decrypt_dir_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Reversed key order for ECB and CBC decryption
    assign cfg_rev = decrypt_dir_reg &&
                     (chain_mode_reg == MODE_ECB || chain_mode_reg == MODE_CBC);
    assign rev     = (state_reg == ST_IDLE) ? cfg_rev
                   : (dec_reg && (mode_reg == MODE_ECB || mode_reg == MODE_CBC));

    // Key read in the cycle before its round (registered key store read)
    assign rd_round = (state_reg == ST_CRYPT) ? cnt_reg + RND_W'(1) : '0;
    assign rd_addr  = rev ? ~rd_round : rd_round;

    sm4bcm_key_store u_key_store (
        .clk     (clk),
        .wr      (ks_wr),
        .rd_addr (rd_addr),
        .rd_data (rk_mem)
    );

    // Shared round unit
    assign key_sched = (state_reg == ST_KEYGEN);
    assign rk        = key_sched ? ck_word(cnt_reg) : rk_mem;

    sm4bcm_round u_round (
        .words     (words_reg),
        .rk        (rk),
        .key_sched (key_sched),
        .next_word (round_out)
    );

    assign ks     = words_reg;   // {X35, X34, X33, X32}
    assign blk_in = {in_data.block_high, in_data.block_low};

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        words_next     = words_reg;
        blk_next       = blk_reg;
        chain_next     = chain_reg;
        mode_next      = mode_reg;
        dec_next       = dec_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ks_wr          = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    blk_next  = blk_in;
                    mode_next = chain_mode_reg;
                    dec_next  = decrypt_dir_reg;
                    cnt_next  = '0;
                    if (in_data.first_block)
                    begin
                        chain_next = {iv_high_reg, iv_low_reg};
                        words_next = to_words({key_high_reg, key_low_reg} ^ SM4_FK);
                        state_next = ST_KEYGEN;
                    end
                    else
                    begin
                        words_next = cipher_src(chain_mode_reg, decrypt_dir_reg,
                                                blk_in, chain_reg);
                        state_next = ST_CRYPT;
                    end
                end
            end
            ST_KEYGEN:
            begin
                words_next = {round_out, words_reg[3:1]};
                ks_wr.en   = 1'b1;
                ks_wr.addr = cnt_reg;
                ks_wr.data = round_out;
                cnt_next   = cnt_reg + RND_W'(1);
                if (cnt_reg == RND_W'(ROUNDS - 1))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                words_next = cipher_src(mode_reg, dec_reg, blk_reg, chain_reg);
                cnt_next   = '0;
                state_next = ST_CRYPT;
            end
            ST_CRYPT:
            begin
                words_next = {round_out, words_reg[3:1]};
                cnt_next   = cnt_reg + RND_W'(1);
                if (cnt_reg == RND_W'(ROUNDS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    case (mode_reg)
                        MODE_ECB:
                        begin
                            {out_data_next.result_high, out_data_next.result_low} = ks;
                        end
                        MODE_CBC:
                        begin
                            if (dec_reg)
                            begin
                                {out_data_next.result_high,
                                 out_data_next.result_low} = ks ^ chain_reg;
                                chain_next = blk_reg;
                            end
                            else
                            begin
                                {out_data_next.result_high,
                                 out_data_next.result_low} = ks;
                                chain_next = ks;
                            end
                        end
                        MODE_OFB:
                        begin
                            {out_data_next.result_high, out_data_next.result_low} =
                                ks ^ blk_reg;
                            chain_next = ks;
                        end
                        MODE_CFB:
                        begin
                            {out_data_next.result_high, out_data_next.result_low} =
                                ks ^ blk_reg;
                            chain_next = dec_reg ? blk_reg : (ks ^ blk_reg);
                        end
                        default:
                        begin
                            {out_data_next.result_high, out_data_next.result_low} = ks;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            words_reg     <= '0;
            blk_reg       <= '0;
            chain_reg     <= '0;
            mode_reg      <= MODE_ECB;
            dec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            words_reg     <= words_next;
            blk_reg       <= blk_next;
            chain_reg     <= chain_next;
            mode_reg      <= mode_next;
            dec_reg       <= dec_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // A result appears only from the finishing cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finishing cycle");

    // A message start always runs the key schedule
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_data.first_block) |=> (state_reg == ST_KEYGEN))
        else $error("first block did not start the key schedule");

    // Cipher rounds start from round zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CRYPT) ##1 (state_reg == ST_CRYPT) |-> (cnt_reg == '0))
        else $error("cipher rounds did not start at round zero");

    // Chaining value changes only at a message start or a finished block
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(chain_reg) |->
            $past(state_reg == ST_FINISH || (in_accept && in_data.first_block)))
        else $error("chaining value changed unexpectedly");

endmodule

@@ verif/tb_sm4_block_cipher_modes_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_sm4_block_cipher_modes_core
// Self-checking bench for the SM4 core in ECB, CBC, OFB and CFB, both ways.
// A local predictor mirrors the key schedule, the rounds and the chaining
// value; every accepted request queues its expected block and a monitor
// compares each taken result with the oldest one. Directed requests cover
// reset defaults, the standard known answer, field extremes, register changes
// inside a message and wide register values. Random messages then run under
// four idling profiles on both channels.
// ============================================================================
module tb_sm4_block_cipher_modes_core
    import sm4bcm_pkg::*;
();

    localparam int          LIMIT_CYCLES = 1_000_000;
    localparam int          TAIL_CYCLES  = 100;
    localparam int          PHASE_ITEMS  = 125;
    localparam logic [127:0] FK_WORDS    = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;
    localparam logic [127:0] KAT_TEXT    = 128'h0123456789abcdeffedcba9876543210;
    localparam logic [127:0] KAT_CIPHER  = 128'h681edf34d206965e86b3e94f536e4246;

    // Indexes beyond the last register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam chain_mode_t MODE_ORDER [4] = '{MODE_ECB, MODE_CBC, MODE_OFB, MODE_CFB};
    localparam logic [63:0] PATTERNS [4]   = '{64'h0, 64'hffff_ffff_ffff_ffff,
                                               64'h5555_5555_5555_5555,
                                               64'haaaa_aaaa_aaaa_aaaa};

    // S-box, entry 0 in the top byte
    localparam logic [0:255][7:0] SBOX = {
        128'hd690e9fecce13db716b614c228fb2c05, 128'h2b679a762abe04c3aa44132649860699,
        128'h9c4250f491ef987a33540b43edcfac62, 128'he4b31ca9c908e89580df94fa758f3fa6,
        128'h4707a7fcf37317ba83593c19e6854fa8, 128'h686b81b27164da8bf8eb0f4b70569d35,
        128'h1e240e5e6358d1a225227c3b01217887, 128'hd40046579fd327524c3602e7a0c4c89e,
        128'heabf8ad240c738b5a3f7f2cef96115a1, 128'he0ae5da49b341a55ad933230f58cb1e3,
        128'h1df6e22e8266ca60c02923ab0d534e6f, 128'hd5db3745defd8e2f03ff6a726d6c5b51,
        128'h8d1baf92bbddbc7f11d95c411f105ad8, 128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
        128'h8969974a0c96777e65b9f109c56ec684, 128'h18f07dec3adc4d2079ee5f3ed7cb3948
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_t                  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_t                 out_data;

    // Predictor state
    logic [127:0] key_reg;
    logic [127:0] iv_reg;
    chain_mode_t  mode_reg;
    logic         dir_reg;
    logic [31:0]  round_keys [32];
    logic [127:0] chain_reg;
    bit           keys_loaded;

    out_t        pending_blocks [$];
    out_t        want_block;
    int          error_count    = 0;
    int          blocks_sent    = 0;
    int          blocks_checked = 0;
    int unsigned cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          stall_pct      = 0;

    sm4_block_cipher_modes_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] x);
        return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function automatic logic [31:0] data_mix(input logic [31:0] x);
        logic [31:0] b;
        b = sub_word(x);
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic logic [31:0] key_mix(input logic [31:0] x);
        logic [31:0] b;
        b = sub_word(x);
        return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // CK: byte j of word i is (4i + j) * 7 mod 256, top byte first
    function automatic logic [31:0] ck_const(input int i);
        logic [31:0] w;
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            w = {w[23:0], 8'((4 * i + j) * 7)};
        end
        return w;
    endfunction

    function automatic void build_round_keys();
        logic [31:0] k [4];
        logic [31:0] nxt;
        for (int j = 0; j < 4; j++)
        begin
            k[j] = key_reg[127 - 32 * j -: 32] ^ FK_WORDS[127 - 32 * j -: 32];
        end
        for (int i = 0; i < 32; i++)
        begin
            nxt  = k[0] ^ key_mix(k[1] ^ k[2] ^ k[3] ^ ck_const(i));
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = nxt;
            round_keys[i] = nxt;
        end
    endfunction

    // 32 rounds; reverse walks the key store backwards (decryption)
    function automatic logic [127:0] sm4_rounds(input logic [127:0] blk, input logic reverse);
        logic [31:0] x [4];
        logic [31:0] nxt;
        for (int j = 0; j < 4; j++)
        begin
            x[j] = blk[127 - 32 * j -: 32];
        end
        for (int i = 0; i < 32; i++)
        begin
            nxt  = x[0] ^ data_mix(x[1] ^ x[2] ^ x[3] ^ round_keys[reverse ? 31 - i : i]);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nxt;
        end
        return {x[3], x[2], x[1], x[0]};
    endfunction

    // Expected output block for one request; advances the chaining value
    function automatic out_t predict_block(input in_t req);
        logic [127:0] blk;
        logic [127:0] res;
        out_t         predicted;
        blk = {req.block_high, req.block_low};
        if (req.first_block)
        begin
            build_round_keys();
            chain_reg = iv_reg;
        end
        case (mode_reg)
            MODE_ECB:
            begin
                res = sm4_rounds(blk, dir_reg);
            end
            MODE_CBC:
            begin
                if (dir_reg)
                begin
                    res       = sm4_rounds(blk, 1'b1) ^ chain_reg;
                    chain_reg = blk;
                end
                else
                begin
                    res       = sm4_rounds(chain_reg ^ blk, 1'b0);
                    chain_reg = res;
                end
            end
            MODE_OFB:
            begin
                chain_reg = sm4_rounds(chain_reg, 1'b0);
                res       = chain_reg ^ blk;
            end
            default:
            begin
                res       = sm4_rounds(chain_reg, 1'b0) ^ blk;
                chain_reg = dir_reg ? blk : res;
            end
        endcase
        predicted.result_high = res[127:64];
        predicted.result_low  = res[63:0];
        return predicted;
    endfunction

    // Mostly random words, with all-zero and all-one values now and then
    function automatic logic [63:0] rand_word();
        case ($urandom_range(15))
            0:       return 64'h0;
            1:       return 64'hffff_ffff_ffff_ffff;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_KEY_HIGH:    key_reg[127:64] = value;
            CFG_KEY_LOW:     key_reg[63:0]   = value;
            CFG_IV_HIGH:     iv_reg[127:64]  = value;
            CFG_IV_LOW:      iv_reg[63:0]    = value;
            CFG_CHAIN_MODE:  mode_reg        = chain_mode_t'(value[1:0]);
            CFG_DECRYPT_DIR: dir_reg         = value[0];
            default:         ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_key_iv(input logic [127:0] key, input logic [127:0] iv);
        write_reg(CFG_KEY_HIGH, key[127:64]);
        write_reg(CFG_KEY_LOW, key[63:0]);
        write_reg(CFG_IV_HIGH, iv[127:64]);
        write_reg(CFG_IV_LOW, iv[63:0]);
    endtask

    // One block request, with an optional sender gap in front of it
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic is_first);
        in_t req;
        req.block_high  = hi;
        req.block_low   = lo;
        // round keys must exist before a continuing block
        req.first_block = is_first | ~keys_loaded;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 70)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        pending_blocks.push_back(predict_block(req));
        keys_loaded = 1'b1;
        blocks_sent++;
    endtask

    // Hold the sender off until every expected block has been taken
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_known_answer();
        // reset defaults: zero key and IV, ECB encrypt
        send_block(64'h0, 64'h0, 1'b1);
        wait_idle();
        write_key_iv(KAT_TEXT, ~KAT_TEXT);
        send_block(KAT_TEXT[127:64], KAT_TEXT[63:0], 1'b1);
        if ({pending_blocks[$].result_high, pending_blocks[$].result_low} !== KAT_CIPHER)
        begin
            $error("known answer: expected %h, predicted %h", KAT_CIPHER,
                   {pending_blocks[$].result_high, pending_blocks[$].result_low});
            error_count++;
        end
        // direction flipped inside the message: reversed keys, no reload
        wait_idle();
        write_reg(CFG_DECRYPT_DIR, 64'h1);
        send_block(KAT_CIPHER[127:64], KAT_CIPHER[63:0], 1'b0);
        wait_idle();
    endtask

    task automatic test_field_extremes();
        for (int d = 0; d < 2; d++)
        begin
            for (int m = 0; m < 4; m++)
            begin
                wait_idle();
                write_key_iv(d ? 128'h0 : ~128'h0, d ? ~128'h0 : 128'h0);
                write_reg(CFG_CHAIN_MODE, 64'(MODE_ORDER[m]));
                write_reg(CFG_DECRYPT_DIR, 64'(d));
                send_block(PATTERNS[m], PATTERNS[3 - m], 1'b1);
                send_block(PATTERNS[(m + 1) % 4], PATTERNS[(m + 2) % 4], 1'b0);
            end
        end
        wait_idle();
    endtask

    task automatic test_mid_message_changes();
        write_key_iv({rand_word(), rand_word()}, {rand_word(), rand_word()});
        write_reg(CFG_CHAIN_MODE, 64'(MODE_CBC));
        write_reg(CFG_DECRYPT_DIR, 64'h0);
        send_block(rand_word(), rand_word(), 1'b1);
        send_block(rand_word(), rand_word(), 1'b0);
        wait_idle();
        // new key and IV wait for the next message start; mode and direction
        // apply at once, upper bits of narrow registers are dropped
        write_key_iv({rand_word(), rand_word()}, {rand_word(), rand_word()});
        write_reg(CFG_CHAIN_MODE, {{62{1'b1}}, MODE_CFB});
        write_reg(CFG_DECRYPT_DIR, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_SPARE_A, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_SPARE_B, 64'h0);
        send_block(rand_word(), rand_word(), 1'b0);
        send_block(rand_word(), rand_word(), 1'b0);
        send_block(rand_word(), rand_word(), 1'b1);
        wait_idle();
    endtask

    task automatic test_random_messages(input int items, input int idle_pct, input int stall);
        int sent;
        int len;
        wait_idle();
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        sent          = 0;
        while (sent < items)
        begin
            // fresh settings for some messages, the rest reuse the last ones
            if (sent == 0 || $urandom_range(99) < 40)
            begin
                wait_idle();
                write_key_iv({rand_word(), rand_word()}, {rand_word(), rand_word()});
                write_reg(CFG_CHAIN_MODE, rand_word());
                write_reg(CFG_DECRYPT_DIR, rand_word());
            end
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                // a stray restart now and then
                send_block(rand_word(), rand_word(), i == 0 || $urandom_range(19) == 0);
                sent++;
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls and the checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_blocks.size() == 0)
            begin
                $error("unexpected result %h", out_data);
                error_count++;
            end
            else
            begin
                want_block = pending_blocks.pop_front();
                if (out_data.result_high !== want_block.result_high)
                begin
                    $error("result_high: expected %h, got %h",
                           want_block.result_high, out_data.result_high);
                    error_count++;
                end
                if (out_data.result_low !== want_block.result_low)
                begin
                    $error("result_low: expected %h, got %h",
                           want_block.result_low, out_data.result_low);
                    error_count++;
                end
                blocks_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout with %0d blocks outstanding", pending_blocks.size());
            $display("tb_sm4_block_cipher_modes_core: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        key_reg     = '0;
        iv_reg      = '0;
        mode_reg    = MODE_ECB;
        dir_reg     = 1'b0;
        chain_reg   = '0;
        keys_loaded = 1'b0;
        for (int i = 0; i < 32; i++)
        begin
            round_keys[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_known_answer();
        test_field_extremes();
        test_mid_message_changes();
        test_random_messages(PHASE_ITEMS, 0, 0);
        test_random_messages(PHASE_ITEMS, 75, 0);
        test_random_messages(PHASE_ITEMS, 0, 75);
        test_random_messages(PHASE_ITEMS, 8, 8);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d blocks sent, %0d checked: ECB, CBC, OFB, CFB both ways, restarts",
                 blocks_sent, blocks_checked);
        $display("and register changes inside messages, under four idling profiles");
        if (error_count == 0)
        begin
            $display("tb_sm4_block_cipher_modes_core: PASS");
        end
        else
        begin
            $display("tb_sm4_block_cipher_modes_core: FAIL");
        end
        $finish;
    end

endmodule
